// File: rtl/rmf_pkg.sv
`timescale 1ns / 1ps

package rmf_pkg;

   localparam int WINDOW      = 17;
   localparam int HALF        = WINDOW / 2;
   localparam int SPAN        = 2 * HALF + 1;
   localparam int SAMPLE_BITS = 16;
   localparam int TAG_BITS    = 16;
   localparam int CNT_BITS    = $clog2(HALF + 2);
   localparam int RND_BITS    = $clog2(SPAN);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [TAG_BITS-1:0]           tag_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [TAG_BITS-1:0]           time_tag;
      logic                          last;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] median;
      logic [TAG_BITS-1:0]           out_time_tag;
      logic                          end_of_stream;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SORT,
      ST_EMIT
   } state_type;

endpackage

// File: rtl/rmf_cx_row.sv
`timescale 1ns / 1ps

// One round of odd-even transposition sort: the pairs that start on the
// given parity are compare-exchanged, smaller value to the lower index.
module rmf_cx_row
   import rmf_pkg::*;
(
   input  sample_type win_i [SPAN],
   input  logic       phase_i,
   output sample_type win_o [SPAN]
);

   always_comb begin
      for (int j = 0; j < SPAN; j++) begin
         if ((j + 1 < SPAN) && (j[0] == phase_i)) begin
            win_o[j] = ($signed(win_i[j]) > $signed(win_i[j+1])) ? win_i[j+1] : win_i[j];
         end else if ((j >= 1) && (j[0] != phase_i)) begin
            win_o[j] = ($signed(win_i[j-1]) > $signed(win_i[j])) ? win_i[j-1] : win_i[j];
         end else begin
            win_o[j] = win_i[j];
         end
      end
   end

endmodule

// File: rtl/recursive_median_filter_core.sv
`timescale 1ns / 1ps
// A request that completes a window gives its result in the output register after a window
// load, 17 sort rounds and an emit step, which waits while rsp_stall holds the output.
// Requests are stalled while a window is in work; one that only fills the lookahead is taken
// in idle. A final request flushes up to 9 results, each in turn through the shared sort row.
// Synchronous active-high reset clears the sequencer, fill count and stream flag.
module recursive_median_filter_core
   import rmf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   state_type              state_ff, state_in;
   logic                   started_ff, started_in;
   logic [CNT_BITS-1:0]    fill_ff, fill_in;
   logic [RND_BITS-1:0]    round_ff, round_in;
   sample_type             past_ff [HALF];
   sample_type             past_in [HALF];
   sample_type             qv_ff [HALF+1];
   sample_type             qv_in [HALF+1];
   tag_type                qt_ff [HALF+1];
   tag_type                qt_in [HALF+1];
   sample_type             win_ff [SPAN];
   sample_type             win_in [SPAN];
   sample_type             row_out [SPAN];
   sample_type             pad_ff, pad_in;
   logic                   last_ff, last_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   req_take;
   logic                   emit_go;
   logic                   sort_done;
   logic [CNT_BITS-1:0]    eff_fill;

   rmf_cx_row u_row (
      .win_i   (win_ff),
      .phase_i (round_ff[0]),
      .win_o   (row_out)
   );

   // Handshake and sequencing controls.
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      req_take  = req_valid && (state_ff == ST_IDLE);
      emit_go   = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
      sort_done = (round_ff == RND_BITS'(SPAN - 1));
      eff_fill  = started_ff ? fill_ff : '0;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_payload.last || (eff_fill == CNT_BITS'(HALF)))) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_SORT;
         end
         ST_SORT: begin
            if (sort_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               state_in = (last_ff && (fill_ff > CNT_BITS'(1))) ? ST_LOAD : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      started_in   = started_ff;
      fill_in      = fill_ff;
      round_in     = round_ff;
      past_in      = past_ff;
      qv_in        = qv_ff;
      qt_in        = qt_ff;
      win_in       = win_ff;
      pad_in       = pad_ff;
      last_in      = last_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (req_take) begin
         // The first sample of a stream stands in for the outputs before it.
         if (!started_ff) begin
            for (int i = 0; i < HALF; i++) begin
               past_in[i] = req_payload.sample;
            end
         end
         for (int i = 0; i <= HALF; i++) begin
            if (eff_fill == CNT_BITS'(i)) begin
               qv_in[i] = req_payload.sample;
               qt_in[i] = req_payload.time_tag;
            end
         end
         started_in = 1'b1;
         fill_in    = eff_fill + CNT_BITS'(1);
         pad_in     = req_payload.sample;
         last_in    = req_payload.last;
      end

      if (state_ff == ST_LOAD) begin
         for (int i = 0; i < HALF; i++) begin
            win_in[i] = past_ff[i];
         end
         win_in[HALF] = qv_ff[0];
         // Lookahead slots beyond the queued samples are padded with the last sample.
         for (int a = 1; a <= HALF; a++) begin
            win_in[HALF+a] = (CNT_BITS'(a) < fill_ff) ? qv_ff[a] : pad_ff;
         end
         round_in = '0;
      end

      if (state_ff == ST_SORT) begin
         win_in   = row_out;
         round_in = round_ff + RND_BITS'(1);
      end

      if (emit_go) begin
         rsp_valid_in         = 1'b1;
         rsp_in.median        = win_ff[HALF];
         rsp_in.out_time_tag  = qt_ff[0];
         rsp_in.end_of_stream = last_ff && (fill_ff == CNT_BITS'(1));
         for (int i = 0; i < HALF - 1; i++) begin
            past_in[i] = past_ff[i+1];
         end
         past_in[HALF-1] = win_ff[HALF];
         for (int i = 0; i < HALF; i++) begin
            qv_in[i] = qv_ff[i+1];
            qt_in[i] = qt_ff[i+1];
         end
         fill_in = fill_ff - CNT_BITS'(1);
         if (last_ff && (fill_ff == CNT_BITS'(1))) begin
            started_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         started_ff   <= 1'b0;
         fill_ff      <= '0;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         fill_ff      <= fill_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      past_ff <= past_in;
      qv_ff   <= qv_in;
      qt_ff   <= qt_in;
      win_ff  <= win_in;
      pad_ff  <= pad_in;
      last_ff <= last_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
